[src/mor_pkg.sv]
// shared constants and transaction types for the match outlier rejection unit
package mor_pkg;

  localparam int unsigned MaxMatches = 64;
  localparam int unsigned AddrW      = 6;
  localparam int unsigned CntW       = 7;
  localparam int unsigned DistW      = 16;
  localparam int unsigned SumW       = 38;
  localparam int unsigned ProdW      = 32;
  localparam int unsigned ThrW       = 20;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 16;

  // register indexes
  localparam logic [CfgIdxW-1:0] CfgMinMatches = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgRadius     = 2'd1;

  // reset values of the registers
  localparam logic [CntW-1:0]  MinMatchesRst = 7'd4;
  localparam logic [DistW-1:0] RadiusRst     = 16'd5120;

  // threshold floor, 2.0 pixels at four times the Q8.8 scale
  localparam logic [ThrW-1:0] ThrFloor = 20'd2048;

  typedef struct packed {
    logic [DistW-1:0] distance;
    logic             set_end;
  } in_item_t;

  typedef struct packed {
    logic [AddrW-1:0] match_index;
    logic             keep;
    logic [CntW-1:0]  outlier_count;
    logic             overflow;
    logic             final_res;
  } out_item_t;

endpackage

[src/mor_if.sv]
// valid/ready channel interfaces for input and result transactions
interface mor_in_if;
  logic              valid;
  logic              ready;
  mor_pkg::in_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface mor_out_if;
  logic               valid;
  logic               ready;
  mor_pkg::out_item_t payload;
  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

[src/mor_ram.sv]
// generic single write, single read ram with registered read data
module mor_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

[src/match_outlier_rejection_unit.sv]
// top level: load distances, then divide, root, median select, count and keep pass
// loading takes one transaction per cycle while idle; the last one starts the run
// run length for n matches is set by the single ram read port walked by the median
// selection (n candidates times n compares)
// no input is taken during a run; results leave through a one-entry output register
// rst_ni clears the sequencer, counters and config registers; the distance store is not cleared
module match_outlier_rejection_unit (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [mor_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [mor_pkg::CfgDataW-1:0]   cfg_data_i,
  mor_in_if.sink                         in_s,
  mor_out_if.source                      out_s
);

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StFin  = 3'd1;
  localparam logic [2:0] StPrep = 3'd2;
  localparam logic [2:0] StDiv  = 3'd3;
  localparam logic [2:0] StSqrt = 3'd4;
  localparam logic [2:0] StMed  = 3'd5;
  localparam logic [2:0] StCnt  = 3'd6;
  localparam logic [2:0] StEmit = 3'd7;

  logic [2:0]                     state_q;
  logic [mor_pkg::CntW-1:0]       cnt_q;
  logic                           ovf_q;
  logic [mor_pkg::SumW-1:0]       sum_q;
  logic [mor_pkg::ProdW-1:0]      prod_q;
  logic                           prod_v_q;
  logic [mor_pkg::CntW-1:0]       min_q;
  logic [mor_pkg::DistW-1:0]      rad_q;
  logic [mor_pkg::SumW-1:0]       div_q;
  logic [mor_pkg::CntW-1:0]       rem_q;
  logic [5:0]                     step_q;
  logic [31:0]                    sq_op_q;
  logic [17:0]                    sq_rem_q;
  logic [15:0]                    root_q;
  logic [mor_pkg::CntW-1:0]       ci_q;
  logic [mor_pkg::CntW-1:0]       cj_q;
  logic                           rd_wait_q;
  logic                           cand_ok_q;
  logic [mor_pkg::DistW-1:0]      cand_q;
  logic [mor_pkg::CntW-1:0]       lt_q;
  logic [mor_pkg::CntW-1:0]       le_q;
  logic [mor_pkg::DistW-1:0]      va_q;
  logic [mor_pkg::DistW-1:0]      vb_q;
  logic [mor_pkg::ThrW-1:0]       thr_q;
  logic [mor_pkg::CntW-1:0]       inl_q;
  logic                           reject_q;
  logic [mor_pkg::CntW-1:0]       drop_q;
  logic                           emit_done_q;
  logic                           out_valid_q;
  mor_pkg::out_item_t             out_q;

  logic                           in_acc;
  logic                           store_en;
  logic [mor_pkg::AddrW-1:0]      raddr;
  logic [mor_pkg::DistW-1:0]      rdata;
  logic [7:0]                     div_trial;
  logic                           div_ge;
  logic [19:0]                    sq_trial;
  logic [19:0]                    sq_test;
  logic                           sq_ge;
  logic [mor_pkg::CntW-1:0]       n_last;
  logic [mor_pkg::CntW-1:0]       ka;
  logic [mor_pkg::CntW-1:0]       kb;
  logic [mor_pkg::CntW-1:0]       lt_n;
  logic [mor_pkg::CntW-1:0]       le_n;
  logic [16:0]                    m2;
  logic [mor_pkg::ThrW-1:0]       m5;
  logic [mor_pkg::ThrW-1:0]       r7;
  logic [mor_pkg::ThrW-1:0]       cap4;
  logic [mor_pkg::ThrW-1:0]       thr_max;
  logic [mor_pkg::ThrW-1:0]       thr_d;
  logic                           pass;
  logic [mor_pkg::CntW-1:0]       inl_n;
  logic                           out_free;

  // input handshake and store write
  assign in_s.ready = (state_q == StLoad);
  assign in_acc     = in_s.valid && in_s.ready;
  assign store_en   = in_acc && (cnt_q != mor_pkg::CntW'(mor_pkg::MaxMatches));

  // median walk reads the compare index, everything else the candidate/item index
  assign raddr = (state_q == StMed && cand_ok_q) ? cj_q[mor_pkg::AddrW-1:0]
                                                 : ci_q[mor_pkg::AddrW-1:0];

  mor_ram #(
    .Width (mor_pkg::DistW),
    .Depth (mor_pkg::MaxMatches)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (store_en),
    .waddr_i (cnt_q[mor_pkg::AddrW-1:0]),
    .wdata_i (in_s.payload.distance),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // one restoring divide step and one root step
  assign div_trial = {rem_q, div_q[mor_pkg::SumW-1]};
  assign div_ge    = div_trial >= {1'b0, cnt_q};
  assign sq_trial  = {sq_rem_q, sq_op_q[31:30]};
  assign sq_test   = {2'b00, root_q, 2'b01};
  assign sq_ge     = sq_trial >= sq_test;

  // median ranks and the running rank counts
  assign n_last = cnt_q - 7'd1;
  assign ka     = n_last >> 1;
  assign kb     = cnt_q >> 1;
  assign lt_n   = lt_q + {6'd0, (rdata < cand_q)};
  assign le_n   = le_q + {6'd0, (rdata <= cand_q)};

  // threshold at four times the q8.8 scale
  assign m2      = {1'b0, va_q} + {1'b0, vb_q};
  assign m5      = {1'b0, m2, 2'b00} + {3'b000, m2};
  assign r7      = {1'b0, root_q, 3'b000} - {4'd0, root_q};
  assign cap4    = {2'b00, rad_q, 2'b00};
  always_comb begin
    thr_max = mor_pkg::ThrFloor;
    if (m5 > thr_max) begin
      thr_max = m5;
    end
    if (r7 > thr_max) begin
      thr_max = r7;
    end
    thr_d = (cap4 < thr_max) ? cap4 : thr_max;
  end

  assign pass     = {2'b00, rdata, 2'b00} <= thr_q;
  assign inl_n    = inl_q + {6'd0, pass};
  assign out_free = !out_valid_q || out_s.ready;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_q <= mor_pkg::MinMatchesRst;
      rad_q <= mor_pkg::RadiusRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        mor_pkg::CfgMinMatches: min_q <= cfg_data_i[mor_pkg::CntW-1:0];
        mor_pkg::CfgRadius:     rad_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // square accumulation, one product register ahead of the adder
  always_ff @(posedge clk_i) begin
    if (store_en) begin
      prod_q <= mor_pkg::ProdW'(in_s.payload.distance) *
                mor_pkg::ProdW'(in_s.payload.distance);
    end
  end

  // threshold register
  always_ff @(posedge clk_i) begin
    thr_q <= thr_d;
  end

  // sequencer and datapath
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      sum_q       <= '0;
      prod_v_q    <= 1'b0;
      div_q       <= '0;
      rem_q       <= '0;
      step_q      <= '0;
      sq_op_q     <= '0;
      sq_rem_q    <= '0;
      root_q      <= '0;
      ci_q        <= '0;
      cj_q        <= '0;
      rd_wait_q   <= 1'b0;
      cand_ok_q   <= 1'b0;
      cand_q      <= '0;
      lt_q        <= '0;
      le_q        <= '0;
      va_q        <= '0;
      vb_q        <= '0;
      inl_q       <= '0;
      reject_q    <= 1'b0;
      drop_q      <= '0;
      emit_done_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      prod_v_q <= store_en;
      if (prod_v_q) begin
        sum_q <= sum_q + {6'd0, prod_q};
      end
      unique case (state_q)
        StLoad: begin
          if (in_acc) begin
            if (store_en) begin
              cnt_q <= cnt_q + 7'd1;
            end else begin
              ovf_q <= 1'b1;
            end
            if (in_s.payload.set_end) begin
              state_q <= StFin;
            end
          end
        end
        StFin: begin
          if (cnt_q == '0) begin
            sum_q   <= '0;
            ovf_q   <= 1'b0;
            state_q <= StLoad;
          end else begin
            state_q <= StPrep;
          end
        end
        StPrep: begin
          div_q   <= sum_q;
          rem_q   <= '0;
          step_q  <= '0;
          state_q <= StDiv;
        end
        StDiv: begin
          rem_q  <= div_ge ? 7'(div_trial - {1'b0, cnt_q}) : div_trial[6:0];
          div_q  <= {div_q[mor_pkg::SumW-2:0], div_ge};
          step_q <= step_q + 6'd1;
          if (step_q == 6'(mor_pkg::SumW - 1)) begin
            step_q  <= '0;
            state_q <= StSqrt;
          end
        end
        StSqrt: begin
          step_q <= step_q + 6'd1;
          if (step_q == '0) begin
            // mean of squares stays below 2^32
            sq_op_q  <= div_q[31:0];
            sq_rem_q <= '0;
            root_q   <= '0;
          end else begin
            sq_rem_q <= sq_ge ? 18'(sq_trial - sq_test) : sq_trial[17:0];
            root_q   <= {root_q[14:0], sq_ge};
            sq_op_q  <= {sq_op_q[29:0], 2'b00};
            if (step_q == 6'd16) begin
              ci_q      <= '0;
              cand_ok_q <= 1'b0;
              rd_wait_q <= 1'b0;
              state_q   <= StMed;
            end
          end
        end
        StMed: begin
          rd_wait_q <= !rd_wait_q;
          if (rd_wait_q) begin
            if (!cand_ok_q) begin
              cand_q    <= rdata;
              cand_ok_q <= 1'b1;
              cj_q      <= '0;
              lt_q      <= '0;
              le_q      <= '0;
            end else begin
              lt_q <= lt_n;
              le_q <= le_n;
              cj_q <= cj_q + 7'd1;
              if (cj_q == n_last) begin
                // candidate holds rank ka or kb when lt <= k < le
                if (lt_n <= ka && ka < le_n) begin
                  va_q <= cand_q;
                end
                if (lt_n <= kb && kb < le_n) begin
                  vb_q <= cand_q;
                end
                cand_ok_q <= 1'b0;
                ci_q      <= ci_q + 7'd1;
                if (ci_q == n_last) begin
                  ci_q    <= '0;
                  inl_q   <= '0;
                  state_q <= StCnt;
                end
              end
            end
          end
        end
        StCnt: begin
          rd_wait_q <= !rd_wait_q;
          if (rd_wait_q) begin
            inl_q <= inl_n;
            ci_q  <= ci_q + 7'd1;
            if (ci_q == n_last) begin
              reject_q    <= (cnt_q > min_q) && (inl_n >= min_q);
              drop_q      <= cnt_q - inl_n;
              ci_q        <= '0;
              emit_done_q <= 1'b0;
              state_q     <= StEmit;
            end
          end
        end
        StEmit: begin
          if (emit_done_q) begin
            if (out_s.ready) begin
              out_valid_q <= 1'b0;
            end
            if (out_free) begin
              cnt_q   <= '0;
              sum_q   <= '0;
              ovf_q   <= 1'b0;
              state_q <= StLoad;
            end
          end else if (!rd_wait_q) begin
            rd_wait_q <= 1'b1;
            if (out_s.ready) begin
              out_valid_q <= 1'b0;
            end
          end else if (out_free) begin
            out_valid_q               <= 1'b1;
            out_q.match_index         <= ci_q[mor_pkg::AddrW-1:0];
            out_q.keep                <= !reject_q || pass;
            out_q.outlier_count       <= (ci_q == n_last && reject_q) ? drop_q : '0;
            out_q.overflow            <= ovf_q;
            out_q.final_res           <= (ci_q == n_last);
            rd_wait_q                 <= 1'b0;
            ci_q                      <= ci_q + 7'd1;
            if (ci_q == n_last) begin
              emit_done_q <= 1'b1;
            end
          end
        end
        default: state_q <= StLoad;
      endcase
    end
  end

  assign out_s.valid   = out_valid_q;
  assign out_s.payload = out_q;

  // results appear only during the emit pass
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (state_q == StEmit || state_q == StLoad))
    else $error("result valid outside the emit pass");

  // the store never holds more than its capacity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= mor_pkg::CntW'(mor_pkg::MaxMatches))
    else $error("loaded count beyond capacity");

  // only the final result carries a dropped count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_s.valid && !out_s.payload.final_res) |-> (out_s.payload.outlier_count == '0))
    else $error("dropped count on a non-final result");

  // a new run starts with cleared counters after the final result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit && emit_done_q && out_free) |=> (cnt_q == '0 && !ovf_q))
    else $error("run state not cleared after the final result");

endmodule
